>>> rtl/mpba_pkg.sv
`timescale 1ns / 1ps

package mpba_pkg;

    // Number of pools that own a block count register
    localparam int CFG_REGS   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam int POOL_W  = 3;
    localparam int INDEX_W = 6;
    localparam int GRANT_W = 5;
    localparam int COUNT_W = 6;
    localparam int STAT_W  = 32;

    typedef enum logic [1:0] {
        OP_ALLOC       = 2'd0,
        OP_FREE        = 2'd1,
        OP_CLEAR_STATS = 2'd2,
        OP_READ_STATS  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_INVALID   = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    typedef logic [CFG_REGS-1:0][CFG_DATA_W-1:0] t_cfg_regs;

    typedef struct packed {
        t_op                op;
        logic [POOL_W-1:0]  pool;
        logic [INDEX_W-1:0] block_index;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [GRANT_W-1:0] granted_index;
        logic [COUNT_W-1:0] used_now;
        logic [COUNT_W-1:0] peak_used;
        logic [STAT_W-1:0]  allocs_total;
        logic [STAT_W-1:0]  frees_total;
        logic [STAT_W-1:0]  fails_total;
    } t_res;

endpackage

>>> rtl/mpba_first_free.sv
`timescale 1ns / 1ps

module mpba_first_free #(
    parameter int WIDTH = 32,
    parameter int IDX_W = 5
) (
    input  logic [WIDTH-1:0] i_free,
    output logic             o_found,
    output logic [IDX_W-1:0] o_index
);

    // Lowest set bit wins: scan from the top so lower bits overwrite
    always_comb begin
        o_index = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_free[i]) begin
                o_index = IDX_W'(i);
            end
        end
        o_found = |i_free;
    end

endmodule

>>> rtl/mpba_pool_core.sv
`timescale 1ns / 1ps

module mpba_pool_core #(
    parameter int POOL_COUNT = 4,
    parameter int MAX_BLOCKS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  mpba_pkg::t_req    i_req,
    input  mpba_pkg::t_cfg_regs i_counts,
    output mpba_pkg::t_res    o_res
);

    import mpba_pkg::*;

    localparam int PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [6:0] MAX7 = 7'(MAX_BLOCKS);

    logic [MAX_BLOCKS-1:0] r_map   [POOL_COUNT];
    logic [CW-1:0]         r_used  [POOL_COUNT];
    logic [CW-1:0]         r_peak  [POOL_COUNT];
    logic [STAT_W-1:0]     r_alloc [POOL_COUNT];
    logic [STAT_W-1:0]     r_free  [POOL_COUNT];
    logic [STAT_W-1:0]     r_fail  [POOL_COUNT];

    logic [MAX_BLOCKS-1:0] n_map   [POOL_COUNT];
    logic [CW-1:0]         n_used  [POOL_COUNT];
    logic [CW-1:0]         n_peak  [POOL_COUNT];
    logic [STAT_W-1:0]     n_alloc [POOL_COUNT];
    logic [STAT_W-1:0]     n_free  [POOL_COUNT];
    logic [STAT_W-1:0]     n_fail  [POOL_COUNT];

    logic                  pool_ok;
    logic                  clear_all;
    logic [PW-1:0]         sel;
    logic [6:0]            cnt7;
    logic [6:0]            cfg_ext;
    logic [MAX_BLOCKS-1:0] avail;
    logic                  found;
    logic [BW-1:0]         grant;
    logic                  idx_ok;
    logic                  idx_used;

    logic [MAX_BLOCKS-1:0] new_map;
    logic [CW-1:0]         new_used;
    logic [CW-1:0]         new_peak;
    logic [STAT_W-1:0]     new_alloc;
    logic [STAT_W-1:0]     new_free;
    logic [STAT_W-1:0]     new_fail;
    t_status               status;
    logic [GRANT_W-1:0]    granted;

    assign pool_ok   = ({1'b0, i_req.pool} < 4'(POOL_COUNT));
    assign clear_all = (i_req.op == OP_CLEAR_STATS) && ({1'b0, i_req.pool} == 4'(POOL_COUNT));
    assign sel       = pool_ok ? i_req.pool[PW-1:0] : '0;

    // Effective block count: register value capped at the pool size
    always_comb begin
        cfg_ext = '0;
        cnt7    = MAX7;
        if ({1'b0, i_req.pool} < 4'(CFG_REGS)) begin
            cfg_ext = {1'b0, i_counts[i_req.pool[CFG_IDX_W-1:0]]};
            if (cfg_ext < MAX7) begin
                cnt7 = cfg_ext;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            avail[i] = !r_map[sel][i] && (7'(i) < cnt7);
        end
    end

    mpba_first_free #(
        .WIDTH (MAX_BLOCKS),
        .IDX_W (BW)
    ) u_first_free (
        .i_free  (avail),
        .o_found (found),
        .o_index (grant)
    );

    assign idx_ok   = ({1'b0, i_req.block_index} < cnt7);
    assign idx_used = r_map[sel][i_req.block_index[BW-1:0]];

    // Work out the addressed pool's state after this item
    always_comb begin
        new_map   = r_map[sel];
        new_used  = r_used[sel];
        new_peak  = r_peak[sel];
        new_alloc = r_alloc[sel];
        new_free  = r_free[sel];
        new_fail  = r_fail[sel];
        status    = ST_OK;
        granted   = '0;
        unique case (i_req.op)
            OP_ALLOC: begin
                if (found) begin
                    new_map[grant] = 1'b1;
                    new_used       = r_used[sel] + 1'b1;
                    new_alloc      = r_alloc[sel] + 1'b1;
                    if (new_used > r_peak[sel]) begin
                        new_peak = new_used;
                    end
                    granted = GRANT_W'(grant);
                end else begin
                    new_fail = r_fail[sel] + 1'b1;
                    status   = ST_FULL;
                end
            end
            OP_FREE: begin
                if (!idx_ok) begin
                    status = ST_INVALID;
                end else if (!idx_used) begin
                    status = ST_NOT_ALLOC;
                end else begin
                    new_map[i_req.block_index[BW-1:0]] = 1'b0;
                    if (r_used[sel] != '0) begin
                        new_used = r_used[sel] - 1'b1;
                    end
                    new_free = r_free[sel] + 1'b1;
                end
            end
            OP_CLEAR_STATS: begin
                new_peak  = '0;
                new_alloc = '0;
                new_free  = '0;
                new_fail  = '0;
            end
            OP_READ_STATS: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res = '0;
        if (clear_all) begin
            o_res.status = ST_OK;
        end else if (!pool_ok) begin
            o_res.status = ST_INVALID;
        end else begin
            o_res.status        = status;
            o_res.granted_index = granted;
            o_res.used_now      = COUNT_W'(new_used);
            o_res.peak_used     = COUNT_W'(new_peak);
            o_res.allocs_total  = new_alloc;
            o_res.frees_total   = new_free;
            o_res.fails_total   = new_fail;
        end
    end

    always_comb begin
        n_map   = r_map;
        n_used  = r_used;
        n_peak  = r_peak;
        n_alloc = r_alloc;
        n_free  = r_free;
        n_fail  = r_fail;
        if (i_fire) begin
            if (clear_all) begin
                for (int k = 0; k < POOL_COUNT; k++) begin
                    n_peak[k]  = '0;
                    n_alloc[k] = '0;
                    n_free[k]  = '0;
                    n_fail[k]  = '0;
                end
            end else if (pool_ok) begin
                n_map[sel]   = new_map;
                n_used[sel]  = new_used;
                n_peak[sel]  = new_peak;
                n_alloc[sel] = new_alloc;
                n_free[sel]  = new_free;
                n_fail[sel]  = new_fail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < POOL_COUNT; k++) begin
                r_map[k]   <= '0;
                r_used[k]  <= '0;
                r_peak[k]  <= '0;
                r_alloc[k] <= '0;
                r_free[k]  <= '0;
                r_fail[k]  <= '0;
            end
        end else begin
            r_map   <= n_map;
            r_used  <= n_used;
            r_peak  <= n_peak;
            r_alloc <= n_alloc;
            r_free  <= n_free;
            r_fail  <= n_fail;
        end
    end

endmodule

>>> rtl/multi_pool_block_allocator.sv
`timescale 1ns / 1ps

// Block allocator for several pools of fixed-size blocks.
// Request channel (i_in_valid / o_in_ready) carries op, pool and block index;
// result channel (o_out_valid / i_out_ready) returns exactly one result per
// request, in order: status, granted index, used and peak count and the three
// wrapping counters of the addressed pool after the request.
// Each request is held in an input register, processed by the allocation
// logic (first-free search over the pool's used bitmap) and caught in a
// result register. One request per cycle is taken while results are
// drained.
// The pool state updates when a request moves into the result register, so
// a following request always sees the effects of the one before it.
// If the receiver stalls, the result register holds, the input register
// fills, and o_in_ready drops until the result is taken.
// Reset (synchronous, active low) frees every block, clears all counters
// and sets each block count register to 32. Block counts are written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must do so only while no
// request is in flight, as the block itself does not enforce it.
module multi_pool_block_allocator #(
    parameter int POOL_COUNT = 4,
    parameter int MAX_BLOCKS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [mpba_pkg::POOL_W-1:0]     i_pool,
    input  logic [mpba_pkg::INDEX_W-1:0]    i_block_index,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_status,
    output logic [mpba_pkg::GRANT_W-1:0]    o_granted_index,
    output logic [mpba_pkg::COUNT_W-1:0]    o_used_now,
    output logic [mpba_pkg::COUNT_W-1:0]    o_peak_used,
    output logic [mpba_pkg::STAT_W-1:0]     o_allocs_total,
    output logic [mpba_pkg::STAT_W-1:0]     o_frees_total,
    output logic [mpba_pkg::STAT_W-1:0]     o_fails_total,
    input  logic                            i_cfg_we,
    input  logic [mpba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mpba_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import mpba_pkg::*;

    localparam logic [CFG_DATA_W-1:0] CNT_RESET = CFG_DATA_W'(32);

    t_cfg_regs r_counts;
    t_req      r_req;
    logic      r_req_valid;
    t_res      r_res;
    logic      r_res_valid;
    t_res      core_res;
    logic      advance;
    logic      in_xfer;

    // Move the held request into the result register when that slot frees
    assign advance    = r_req_valid && (!r_res_valid || i_out_ready);
    assign o_in_ready = !r_req_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Block count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_REGS; k++) begin
                r_counts[k] <= CNT_RESET;
            end
        end else if (i_cfg_we) begin
            r_counts[i_cfg_index] <= i_cfg_data;
        end
    end

    // Input register: hold the request until it advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (in_xfer) begin
            r_req_valid <= 1'b1;
        end else if (advance) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req.op          <= t_op'(i_op);
            r_req.pool        <= i_pool;
            r_req.block_index <= i_block_index;
        end
    end

    mpba_pool_core #(
        .POOL_COUNT (POOL_COUNT),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_req    (r_req),
        .i_counts (r_counts),
        .o_res    (core_res)
    );

    // Result register: hold while the receiver stalls, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid     = r_res_valid;
    assign o_status        = r_res.status;
    assign o_granted_index = r_res.granted_index;
    assign o_used_now      = r_res.used_now;
    assign o_peak_used     = r_res.peak_used;
    assign o_allocs_total  = r_res.allocs_total;
    assign o_frees_total   = r_res.frees_total;
    assign o_fails_total   = r_res.fails_total;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

// Checks the multi-pool block allocator against a cycle-free predictor of the
// pool state. Directed tests cover the reset state, allocate and free, bad
// pools, full pools and statistics clearing. Random traffic then runs in
// four phases. Each phase has its own block counts, its own mix of idle and
// stall, and one pool that gets most of the load.
module tb_top;

    import mpba_pkg::*;

    localparam int POOL_COUNT   = 4;
    localparam int MAX_BLOCKS   = 32;
    localparam int DRAIN_CYCLES = 6;
    localparam int LIMIT_CYCLES = 200000;

    // Block count register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NET_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_COUNT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DMA_COUNT   = 2'd3;

    // Pool number that addresses every pool for a statistics clear
    localparam logic [POOL_W-1:0] POOL_ALL = POOL_W'(POOL_COUNT);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_op;
    logic [POOL_W-1:0]     i_pool;
    logic [INDEX_W-1:0]    i_block_index;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_status;
    logic [GRANT_W-1:0]    o_granted_index;
    logic [COUNT_W-1:0]    o_used_now;
    logic [COUNT_W-1:0]    o_peak_used;
    logic [STAT_W-1:0]     o_allocs_total;
    logic [STAT_W-1:0]     o_frees_total;
    logic [STAT_W-1:0]     o_fails_total;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    multi_pool_block_allocator #(
        .POOL_COUNT (POOL_COUNT),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_pool          (i_pool),
        .i_block_index   (i_block_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_used_now      (o_used_now),
        .o_peak_used     (o_peak_used),
        .o_allocs_total  (o_allocs_total),
        .o_frees_total   (o_frees_total),
        .o_fails_total   (o_fails_total),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predicted pool state: block counts, used bitmaps and statistics
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] pool_limit_reg [POOL_COUNT];
    logic [MAX_BLOCKS-1:0] pool_map    [POOL_COUNT];
    logic [COUNT_W-1:0]    pool_used   [POOL_COUNT];
    logic [COUNT_W-1:0]    pool_peak   [POOL_COUNT];
    logic [STAT_W-1:0]     pool_allocs [POOL_COUNT];
    logic [STAT_W-1:0]     pool_frees  [POOL_COUNT];
    logic [STAT_W-1:0]     pool_fails  [POOL_COUNT];

    // Answers predicted for accepted requests, oldest first
    t_res pool_answer_q [$];

    int send_idle_pct;
    int out_stall_pct;
    int error_count;
    int answers_checked;
    int requests_sent;
    int count_writes;
    int cycle_count = 0;
    int op_seen     [4];
    int status_seen [4];

    task automatic report_error(string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [STAT_W-1:0] got, logic [STAT_W-1:0] want);
        if (got !== want)
            report_error($sformatf("answer %0d: %s is %0h, expected %0h",
                                   answers_checked, name, got, want));
    endtask

    function automatic logic [COUNT_W-1:0] usable_blocks(int p);
        return (pool_limit_reg[p] > MAX_BLOCKS) ? COUNT_W'(MAX_BLOCKS) : pool_limit_reg[p];
    endfunction

    // Apply one request to the predicted state and return the answer
    function automatic t_res predict_pool_answer(t_op op, logic [POOL_W-1:0] pool,
                                                 logic [INDEX_W-1:0] idx);
        t_res                r;
        int                  lim;
        int                  slot;
        bit                  found;
        r        = '0;
        r.status = ST_OK;
        if (op == OP_CLEAR_STATS && pool == POOL_ALL) begin
            for (int p = 0; p < POOL_COUNT; p++) begin
                pool_allocs[p] = '0;
                pool_frees[p]  = '0;
                pool_fails[p]  = '0;
                pool_peak[p]   = '0;
            end
            return r;
        end
        if (pool >= POOL_COUNT) begin
            r.status = ST_INVALID;
            return r;
        end
        lim   = usable_blocks(pool);
        found = 1'b0;
        slot  = 0;
        case (op)
            OP_ALLOC: begin
                for (int b = 0; b < lim; b++) begin
                    if (!found && !pool_map[pool][b]) begin
                        found = 1'b1;
                        slot  = b;
                    end
                end
                if (found) begin
                    pool_map[pool][slot] = 1'b1;
                    pool_used[pool]      = pool_used[pool] + 1'b1;
                    pool_allocs[pool]    = pool_allocs[pool] + 1'b1;
                    if (pool_used[pool] > pool_peak[pool])
                        pool_peak[pool] = pool_used[pool];
                    r.granted_index = GRANT_W'(slot);
                end else begin
                    pool_fails[pool] = pool_fails[pool] + 1'b1;
                    r.status         = ST_FULL;
                end
            end
            OP_FREE: begin
                if (idx >= lim) begin
                    r.status = ST_INVALID;
                end else if (!pool_map[pool][idx]) begin
                    r.status = ST_NOT_ALLOC;
                end else begin
                    pool_map[pool][idx] = 1'b0;
                    if (pool_used[pool] != 0)
                        pool_used[pool] = pool_used[pool] - 1'b1;
                    pool_frees[pool] = pool_frees[pool] + 1'b1;
                end
            end
            OP_CLEAR_STATS: begin
                pool_allocs[pool] = '0;
                pool_frees[pool]  = '0;
                pool_fails[pool]  = '0;
                pool_peak[pool]   = '0;
            end
            default: ;
        endcase
        r.used_now     = pool_used[pool];
        r.peak_used    = pool_peak[pool];
        r.allocs_total = pool_allocs[pool];
        r.frees_total  = pool_frees[pool];
        r.fails_total  = pool_fails[pool];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Idle at random, then hold the request until its transfer; valid stays
    // high on return so that back-to-back requests need no gap.
    task automatic send_request(t_op op, logic [POOL_W-1:0] pool, logic [INDEX_W-1:0] idx);
        t_res want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_pool        <= pool;
        i_block_index <= idx;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1)
            @(posedge i_clk);
        want = predict_pool_answer(op, pool, idx);
        pool_answer_q.push_back(want);
        requests_sent++;
        op_seen[op]++;
        status_seen[want.status]++;
    endtask

    // Drop valid and wait until every predicted answer has been taken
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pool_answer_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write_cycle(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we            <= 1'b1;
        i_cfg_index         <= idx;
        i_cfg_data          <= val;
        pool_limit_reg[idx]  = val;
        count_writes++;
        @(posedge i_clk);
    endtask

    // Write all four block counts while the block is idle
    task automatic program_block_counts(logic [CFG_DATA_W-1:0] flash_cnt,
                                        logic [CFG_DATA_W-1:0] net_cnt,
                                        logic [CFG_DATA_W-1:0] log_cnt,
                                        logic [CFG_DATA_W-1:0] dma_cnt);
        wait_for_drain();
        cfg_write_cycle(REG_FLASH_COUNT, flash_cnt);
        cfg_write_cycle(REG_NET_COUNT, net_cnt);
        cfg_write_cycle(REG_LOG_COUNT, log_cnt);
        cfg_write_cycle(REG_DMA_COUNT, dma_cnt);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int stall_pct);
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
    endtask

    // ------------------------------------------------------------------
    // Result side: check each transfer against the oldest prediction and
    // pick the next ready at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pool_answer_q.size() == 0) begin
                report_error("answer with no request outstanding");
            end else begin
                want = pool_answer_q.pop_front();
                check_field("status", STAT_W'(o_status), STAT_W'(want.status));
                check_field("granted_index", STAT_W'(o_granted_index),
                            STAT_W'(want.granted_index));
                check_field("used_now", STAT_W'(o_used_now), STAT_W'(want.used_now));
                check_field("peak_used", STAT_W'(o_peak_used), STAT_W'(want.peak_used));
                check_field("allocs_total", o_allocs_total, want.allocs_total);
                check_field("frees_total", o_frees_total, want.frees_total);
                check_field("fails_total", o_fails_total, want.fails_total);
                answers_checked++;
            end
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Every pool reads back empty after reset
    task automatic test_reset_state();
        for (int p = 0; p < POOL_COUNT; p++)
            send_request(OP_READ_STATS, POOL_W'(p), INDEX_W'($urandom_range(63)));
    endtask

    // Lowest free block first, double free, free beyond the count
    task automatic test_alloc_and_free();
        send_request(OP_ALLOC, 3'd0, 6'd0);
        send_request(OP_ALLOC, 3'd0, 6'd63);
        send_request(OP_ALLOC, 3'd0, 6'd0);
        send_request(OP_FREE, 3'd0, 6'd1);
        send_request(OP_FREE, 3'd0, 6'd1);
        send_request(OP_ALLOC, 3'd0, 6'd0);
        send_request(OP_FREE, 3'd0, 6'd63);
    endtask

    // Out-of-range pools answer invalid and touch nothing, not even the fails
    task automatic test_invalid_pools();
        send_request(OP_ALLOC, 3'd7, 6'd0);
        send_request(OP_FREE, POOL_ALL, 6'd0);
        send_request(OP_READ_STATS, 3'd5, 6'd21);
        send_request(OP_CLEAR_STATS, 3'd6, 6'd42);
        send_request(OP_READ_STATS, 3'd0, 6'd0);
    endtask

    // Tiny and zero pools fill at once; a free above the count is invalid
    task automatic test_pool_full();
        program_block_counts(6'd32, 6'd1, 6'd32, 6'd0);
        send_request(OP_ALLOC, 3'd1, 6'd0);
        send_request(OP_ALLOC, 3'd1, 6'd0);
        send_request(OP_ALLOC, 3'd3, 6'd0);
        send_request(OP_FREE, 3'd1, 6'd1);
        send_request(OP_FREE, 3'd1, 6'd0);
    endtask

    // Clearing drops the peak to zero with blocks still held
    task automatic test_stats_clear();
        send_request(OP_CLEAR_STATS, 3'd0, 6'd0);
        send_request(OP_ALLOC, 3'd0, 6'd0);
        send_request(OP_CLEAR_STATS, POOL_ALL, 6'd0);
        send_request(OP_READ_STATS, 3'd0, 6'd0);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly allocate and free on valid pools, half of it
    // aimed at one pool so that it fills; frees mostly hit a held block
    // ------------------------------------------------------------------
    task automatic run_traffic_phase(int items, int alloc_pct, int focus);
        int                 roll;
        int                 p;
        int                 start;
        bit                 picked;
        t_op                op;
        logic [POOL_W-1:0]  pool;
        logic [INDEX_W-1:0] idx;
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(99);
            idx  = INDEX_W'($urandom_range(63));
            p    = ($urandom_range(1) == 1) ? focus : $urandom_range(POOL_COUNT - 1);
            pool = POOL_W'(p);
            if (roll < 6) begin
                pool = POOL_W'($urandom_range(7, POOL_COUNT));
                op   = t_op'($urandom_range(3));
            end else if (roll < 10) begin
                op = OP_CLEAR_STATS;
                if ($urandom_range(1) == 1)
                    pool = POOL_ALL;
            end else if (roll < 20) begin
                op = OP_READ_STATS;
            end else if ($urandom_range(99) < alloc_pct) begin
                op = OP_ALLOC;
            end else begin
                op = OP_FREE;
                if ($urandom_range(3) != 0) begin
                    start  = $urandom_range(MAX_BLOCKS - 1);
                    picked = 1'b0;
                    for (int k = 0; k < MAX_BLOCKS; k++) begin
                        if (!picked && pool_map[p][(start + k) % MAX_BLOCKS]) begin
                            idx    = INDEX_W'((start + k) % MAX_BLOCKS);
                            picked = 1'b1;
                        end
                    end
                end
            end
            send_request(op, pool, idx);
        end
    endtask

    task automatic test_random_traffic();
        // Full-size pools, no idling
        program_block_counts(6'd32, 6'd32, 6'd32, 6'd32);
        set_idling(0, 0);
        run_traffic_phase(125, 60, 0);

        // Counts above the maximum act as 32; fill the dma pool
        program_block_counts(6'd0, 6'd1, 6'd33, 6'd63);
        set_idling(51, 0);
        run_traffic_phase(125, 75, 3);

        // Shrink with blocks held above the new count
        program_block_counts(6'd5, 6'd32, 6'd17, 6'd2);
        set_idling(0, 51);
        run_traffic_phase(125, 55, 2);

        program_block_counts(CFG_DATA_W'($urandom_range(63)), CFG_DATA_W'($urandom_range(63)),
                             CFG_DATA_W'($urandom_range(63)), CFG_DATA_W'($urandom_range(63)));
        set_idling(18, 18);
        run_traffic_phase(125, 50, $urandom_range(POOL_COUNT - 1));
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_op          <= OP_ALLOC;
        i_pool        <= '0;
        i_block_index <= '0;
        i_out_ready   <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_FLASH_COUNT;
        i_cfg_data    <= '0;
        send_idle_pct   = 0;
        out_stall_pct   = 0;
        error_count     = 0;
        answers_checked = 0;
        requests_sent   = 0;
        count_writes    = 0;
        for (int i = 0; i < 4; i++) begin
            op_seen[i]     = 0;
            status_seen[i] = 0;
        end
        // Reset state: every block free, counts 32, statistics cleared
        for (int p = 0; p < POOL_COUNT; p++) begin
            pool_limit_reg[p] = CFG_DATA_W'(MAX_BLOCKS);
            pool_map[p]    = '0;
            pool_used[p]   = '0;
            pool_peak[p]   = '0;
            pool_allocs[p] = '0;
            pool_frees[p]  = '0;
            pool_fails[p]  = '0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_alloc_and_free();
        test_invalid_pools();
        test_pool_full();
        test_stats_clear();
        test_random_traffic();

        wait_for_drain();

        $display("covered: %0d requests (alloc %0d, free %0d, clear %0d, read %0d), %0d count writes",
                 requests_sent, op_seen[OP_ALLOC], op_seen[OP_FREE], op_seen[OP_CLEAR_STATS],
                 op_seen[OP_READ_STATS], count_writes);
        $display("answers: %0d checked; ok %0d, full %0d, invalid %0d, not allocated %0d",
                 answers_checked, status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_INVALID], status_seen[ST_NOT_ALLOC]);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/mpba_pkg.sv
rtl/mpba_first_free.sv
rtl/mpba_pool_core.sv
rtl/multi_pool_block_allocator.sv
dv/tb_top.sv
